// ===== rtl/vnl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnl_pkg: shared constants for the vector normalize and length block
// Formats of the unit outputs and the default component width.
// ----------------------------------------------------------------------------
package vnl_pkg;

	// Default width of one input component.
	localparam int COMPONENT_BITS_DEF = 16;

	// Fraction bits of a unit component (Q1.14) and its port width.
	localparam int UNIT_FRAC = 14;
	localparam int UNIT_BITS = 16;

	// Quotient m^2 * 2^28 / S is at most 2^28, so it needs 29 bits.
	localparam int QUOT_BITS = 2 * UNIT_FRAC + 1;

	// The quotient is padded to an even width for the square root.
	localparam int QROOT_OP_BITS = QUOT_BITS + 1;

endpackage
`default_nettype wire

// ===== rtl/vnl_square.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnl_square: squares and squared length
// Two stages: component magnitudes squared, then the sum of the squares.
// ----------------------------------------------------------------------------
module vnl_square #(
	parameter int C_BITS = vnl_pkg::COMPONENT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  in_valid,
	input  wire logic [C_BITS-1:0]     cx,
	input  wire logic [C_BITS-1:0]     cy,
	input  wire logic [C_BITS-1:0]     cz,
	output logic                       out_valid,
	output logic [2*C_BITS-1:0]        sq_x,
	output logic [2*C_BITS-1:0]        sq_y,
	output logic [2*C_BITS-1:0]        sq_z,
	output logic [2*C_BITS-1:0]        sum,
	output logic [2:0]                 signs,
	output logic                       zero
);
	localparam int SW = 2 * C_BITS;

	logic [C_BITS-1:0] mag_x, mag_y, mag_z;
	logic [SW-1:0]     sq_x_s1, sq_y_s1, sq_z_s1;
	logic [2:0]        sign_s1;
	logic              vld_s1;
	logic [SW-1:0]     sq_x_s2, sq_y_s2, sq_z_s2, sum_s2;
	logic [2:0]        sign_s2;
	logic              zero_s2, vld_s2;

	// Magnitudes; the most negative value maps to its exact unsigned size.
	assign mag_x = cx[C_BITS-1] ? (~cx + 1'b1) : cx;
	assign mag_y = cy[C_BITS-1] ? (~cy + 1'b1) : cy;
	assign mag_z = cz[C_BITS-1] ? (~cz + 1'b1) : cz;

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1 squares each magnitude, stage 2 adds them.
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s1 <= SW'(mag_x) * SW'(mag_x);
			sq_y_s1 <= SW'(mag_y) * SW'(mag_y);
			sq_z_s1 <= SW'(mag_z) * SW'(mag_z);
			sign_s1 <= {cx[C_BITS-1], cy[C_BITS-1], cz[C_BITS-1]};
			sq_x_s2 <= sq_x_s1;
			sq_y_s2 <= sq_y_s1;
			sq_z_s2 <= sq_z_s1;
			sum_s2  <= sq_x_s1 + sq_y_s1 + sq_z_s1;
			zero_s2 <= ((sq_x_s1 | sq_y_s1 | sq_z_s1) == '0);
			sign_s2 <= sign_s1;
		end
	end

	assign out_valid = vld_s2;
	assign sq_x      = sq_x_s2;
	assign sq_y      = sq_y_s2;
	assign sq_z      = sq_z_s2;
	assign sum       = sum_s2;
	assign signs     = sign_s2;
	assign zero      = zero_s2;
endmodule
`default_nettype wire

// ===== rtl/vnl_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnl_isqrt: pipelined integer square root
// One result bit per stage, floor of the root, with a sideband carried along.
// ----------------------------------------------------------------------------
module vnl_isqrt #(
	parameter int OP_BITS = 32,
	parameter int SB_BITS = 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic                  in_valid,
	input  wire logic [OP_BITS-1:0]    op,
	input  wire logic [SB_BITS-1:0]    in_sb,
	output logic                       out_valid,
	output logic [OP_BITS/2-1:0]       root,
	output logic [SB_BITS-1:0]         out_sb
);
	localparam int N  = OP_BITS / 2;
	localparam int RW = N + 3;

	logic [OP_BITS-1:0] op_s   [1:N];
	logic [RW-1:0]      rem_s  [1:N];
	logic [N-1:0]       root_s [1:N];
	logic [SB_BITS-1:0] sb_s   [1:N];
	logic               vld_s  [1:N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [OP_BITS-1:0] cur_op;
		logic [RW-1:0]      cur_rem, rem_sh, trial;
		logic [N-1:0]       cur_root;
		logic [SB_BITS-1:0] cur_sb;
		logic               cur_vld, ge;

		if (i == 0) begin : g_first
			assign cur_op   = op;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_sb   = in_sb;
			assign cur_vld  = in_valid;
		end else begin : g_next
			assign cur_op   = op_s[i];
			assign cur_rem  = rem_s[i];
			assign cur_root = root_s[i];
			assign cur_sb   = sb_s[i];
			assign cur_vld  = vld_s[i];
		end

		// Bring down two operand bits and try the next root bit.
		assign rem_sh = {cur_rem[RW-3:0], cur_op[OP_BITS-1 -: 2]};
		assign trial  = {1'b0, cur_root, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				op_s[i+1]   <= cur_op << 2;
				rem_s[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[i+1] <= {cur_root[N-2:0], ge};
				sb_s[i+1]   <= cur_sb;
			end
		end
	end

	assign out_valid = vld_s[N];
	assign root      = root_s[N];
	assign out_sb    = sb_s[N];
endmodule
`default_nettype wire

// ===== rtl/vnl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnl_div: pipelined restoring divider
// Computes floor(num * 2^(QB-1) / den) for num <= den, one bit per stage.
// ----------------------------------------------------------------------------
module vnl_div #(
	parameter int SW      = 32,
	parameter int SB_BITS = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       in_valid,
	input  wire logic [SW-1:0]              num,
	input  wire logic [SW-1:0]              den,
	input  wire logic [SB_BITS-1:0]         in_sb,
	output logic                            out_valid,
	output logic [vnl_pkg::QUOT_BITS-1:0]   quot,
	output logic [SB_BITS-1:0]              out_sb
);
	localparam int QB = vnl_pkg::QUOT_BITS;

	logic [SW-1:0]      rem_s [1:QB];
	logic [SW-1:0]      den_s [1:QB];
	logic [QB-1:0]      quo_s [1:QB];
	logic [SB_BITS-1:0] sb_s  [1:QB];
	logic               vld_s [1:QB];

	for (genvar j = 0; j < QB; j++) begin : g_step
		logic [SW:0]        r2, den_x, diff;
		logic [SW-1:0]      cur_den;
		logic [QB-1:0]      cur_quo;
		logic [SB_BITS-1:0] cur_sb;
		logic               cur_vld, ge;

		// The first stage takes the numerator unshifted; it is at most den.
		if (j == 0) begin : g_first
			assign r2      = {1'b0, num};
			assign cur_den = den;
			assign cur_quo = '0;
			assign cur_sb  = in_sb;
			assign cur_vld = in_valid;
		end else begin : g_next
			assign r2      = {rem_s[j], 1'b0};
			assign cur_den = den_s[j];
			assign cur_quo = quo_s[j];
			assign cur_sb  = sb_s[j];
			assign cur_vld = vld_s[j];
		end

		assign den_x = {1'b0, cur_den};
		assign ge    = (r2 >= den_x);
		assign diff  = ge ? (r2 - den_x) : r2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1] <= diff[SW-1:0];
				den_s[j+1] <= cur_den;
				quo_s[j+1] <= {cur_quo[QB-2:0], ge};
				sb_s[j+1]  <= cur_sb;
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign quot      = quo_s[QB];
	assign out_sb    = sb_s[QB];
endmodule
`default_nettype wire

// ===== rtl/vector3_normalize_length.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_normalize_length: length and unit direction of a 3D vector
// Squared length, floored length and the Q1.14 unit vector of one item.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  input   | in_valid / in_ready   | comp_x, comp_y, comp_z
//  output  | out_valid / out_ready | length_squared, length, unit_x/y/z,
//          |                       | zero_vector
//
// One item enters per cycle while the pipeline advances. Its stages are the
// squares, the bit-per-stage length root, divider and unit roots, and the output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module vector3_normalize_length #(
	parameter int COMPONENT_BITS = vnl_pkg::COMPONENT_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [COMPONENT_BITS-1:0] comp_x,
	input  wire logic signed [COMPONENT_BITS-1:0] comp_y,
	input  wire logic signed [COMPONENT_BITS-1:0] comp_z,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [2*COMPONENT_BITS-1:0]          length_squared,
	output logic [COMPONENT_BITS-1:0]            length,
	output logic signed [vnl_pkg::UNIT_BITS-1:0] unit_x,
	output logic signed [vnl_pkg::UNIT_BITS-1:0] unit_y,
	output logic signed [vnl_pkg::UNIT_BITS-1:0] unit_z,
	output logic                                 zero_vector
);
	localparam int C     = COMPONENT_BITS;
	localparam int SW    = 2 * C;
	localparam int QB    = vnl_pkg::QUOT_BITS;
	localparam int QOP   = vnl_pkg::QROOT_OP_BITS;
	localparam int QR    = QOP / 2;
	localparam int UB    = vnl_pkg::UNIT_BITS;
	localparam int LSB_W = 4 * SW + 4;
	localparam int XSB_W = SW + C + 2;

	logic adv;

	// Squares.
	logic          sq_valid, sq_zero;
	logic [SW-1:0] sq_x, sq_y, sq_z, sq_sum;
	logic [2:0]    sq_signs;

	// Length root and its sideband.
	logic             len_valid;
	logic [C-1:0]     len_root;
	logic [LSB_W-1:0] len_sb;
	logic [SW-1:0]    l_sq_x, l_sq_y, l_sq_z, l_sum;
	logic [2:0]       l_signs;
	logic             l_zero;

	// Dividers.
	logic             dx_valid, dy_valid, dz_valid;
	logic [QB-1:0]    dx_quot, dy_quot, dz_quot;
	logic [XSB_W-1:0] dx_sb;
	logic             dy_sb, dz_sb;

	// Unit roots.
	logic             ux_valid, uy_valid, uz_valid;
	logic [QR-1:0]    ux_root, uy_root, uz_root;
	logic [XSB_W-1:0] ux_sb;
	logic             uy_sb, uz_sb;
	logic [SW-1:0]    u_sum;
	logic [C-1:0]     u_len;
	logic             u_zero, u_sign_x;

	// Output register.
	logic          out_valid_q, zero_q;
	logic [SW-1:0] len_sq_q;
	logic [C-1:0]  len_q;
	logic [UB-1:0] unit_x_q, unit_y_q, unit_z_q;

	assign adv      = ~out_valid_q | out_ready;
	assign in_ready = adv;

	vnl_square #(.C_BITS(C)) u_square (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(in_valid),
		.cx(comp_x), .cy(comp_y), .cz(comp_z),
		.out_valid(sq_valid), .sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z),
		.sum(sq_sum), .signs(sq_signs), .zero(sq_zero)
	);

	// Length root; the squares travel alongside for the dividers.
	vnl_isqrt #(.OP_BITS(SW), .SB_BITS(LSB_W)) u_len_root (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(sq_valid), .op(sq_sum),
		.in_sb({sq_x, sq_y, sq_z, sq_sum, sq_signs, sq_zero}),
		.out_valid(len_valid), .root(len_root), .out_sb(len_sb)
	);

	assign {l_sq_x, l_sq_y, l_sq_z, l_sum, l_signs, l_zero} = len_sb;

	// Per component, m^2 * 2^28 / S; the x lane carries the shared fields.
	vnl_div #(.SW(SW), .SB_BITS(XSB_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(len_valid),
		.num(l_sq_x), .den(l_sum), .in_sb({l_sum, len_root, l_zero, l_signs[2]}),
		.out_valid(dx_valid), .quot(dx_quot), .out_sb(dx_sb)
	);

	vnl_div #(.SW(SW), .SB_BITS(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(len_valid),
		.num(l_sq_y), .den(l_sum), .in_sb(l_signs[1]),
		.out_valid(dy_valid), .quot(dy_quot), .out_sb(dy_sb)
	);

	vnl_div #(.SW(SW), .SB_BITS(1)) u_div_z (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(len_valid),
		.num(l_sq_z), .den(l_sum), .in_sb(l_signs[0]),
		.out_valid(dz_valid), .quot(dz_quot), .out_sb(dz_sb)
	);

	// The unit magnitude is the floored root of that quotient.
	vnl_isqrt #(.OP_BITS(QOP), .SB_BITS(XSB_W)) u_root_x (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(dx_valid),
		.op({1'b0, dx_quot}), .in_sb(dx_sb),
		.out_valid(ux_valid), .root(ux_root), .out_sb(ux_sb)
	);

	vnl_isqrt #(.OP_BITS(QOP), .SB_BITS(1)) u_root_y (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(dy_valid),
		.op({1'b0, dy_quot}), .in_sb(dy_sb),
		.out_valid(uy_valid), .root(uy_root), .out_sb(uy_sb)
	);

	vnl_isqrt #(.OP_BITS(QOP), .SB_BITS(1)) u_root_z (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(dz_valid),
		.op({1'b0, dz_quot}), .in_sb(dz_sb),
		.out_valid(uz_valid), .root(uz_root), .out_sb(uz_sb)
	);

	assign {u_sum, u_len, u_zero, u_sign_x} = ux_sb;

	// Output register: sign the unit magnitudes, force zeros for a zero vector.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ux_valid & uy_valid & uz_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len_sq_q <= u_sum;
			len_q    <= u_len;
			zero_q   <= u_zero;
			if (u_zero) begin
				unit_x_q <= '0;
				unit_y_q <= '0;
				unit_z_q <= '0;
			end else begin
				unit_x_q <= u_sign_x ? (UB'(0) - UB'(ux_root)) : UB'(ux_root);
				unit_y_q <= uy_sb ? (UB'(0) - UB'(uy_root)) : UB'(uy_root);
				unit_z_q <= uz_sb ? (UB'(0) - UB'(uz_root)) : UB'(uz_root);
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign length_squared = len_sq_q;
	assign length         = len_q;
	assign unit_x         = unit_x_q;
	assign unit_y         = unit_y_q;
	assign unit_z         = unit_z_q;
	assign zero_vector    = zero_q;
endmodule
`default_nettype wire
